>>> hdl/blpd_pkg.sv
`default_nettype none

package blpd_pkg;

  // Number of bars the stores are built for.
  localparam int unsigned BARS = 32;

  // Widths fixed by the word formats.
  localparam int unsigned BAR_IDX_W  = 5;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned PFALL_W    = 8;
  localparam int unsigned STEPMS_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Widths that follow from the bar count.
  localparam int unsigned BAR_W = (BARS > 1) ? $clog2(BARS) : 1;
  localparam int unsigned N_W   = $clog2(BARS + 1);
  localparam int unsigned CMP_W = ((N_W > BAR_IDX_W) ? N_W : BAR_IDX_W) + 1;

  // Decay steps per tick are capped.
  localparam int unsigned MAX_STEPS = 4;
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1);

  // Queue between the front and back end.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAR_COUNT  = 2'd0,
    CFG_FALL_SHIFT = 2'd1,
    CFG_PEAK_FALL  = 2'd2,
    CFG_STEP_MS    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_LEVEL  = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef struct packed {
    logic [CNT_W-1:0]    bar_count;
    logic [SHIFT_W-1:0]  fall_shift;
    logic [PFALL_W-1:0]  peak_fall;
    logic [STEPMS_W-1:0] step_ms;
  } cfg_t;

  typedef struct packed {
    op_e                  op;
    logic [BAR_IDX_W-1:0] bar;
    logic [LEVEL_W-1:0]   level;
    logic [MS_W-1:0]      tick_ms;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] peak;
  } lvl_t;

  typedef struct packed {
    logic                 has_bar;
    logic [BAR_IDX_W-1:0] out_bar;
    logic [LEVEL_W-1:0]   shown_level;
    logic [LEVEL_W-1:0]   peak_level;
    logic                 redraw;
    logic                 decaying;
    logic                 last;
  } result_t;

  // Bars in use: zero counts as one, anything above BARS as BARS.
  function automatic logic [N_W-1:0] bars_in_use(input cfg_t cfg);
    logic [N_W-1:0] n;
    if (cfg.bar_count == '0) begin
      n = N_W'(1);
    end else if (int'(cfg.bar_count) > int'(BARS)) begin
      n = N_W'(BARS);
    end else begin
      n = N_W'(cfg.bar_count);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/blpd_ram.sv
`default_nettype none

module blpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/blpd_front.sv
`default_nettype none

module blpd_front
  import blpd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 action_i,
  input  wire logic [BAR_IDX_W-1:0] bar_index_i,
  input  wire logic [LEVEL_W-1:0]   level_i,
  input  wire logic [MS_W-1:0]      tick_ms_i,
  output logic                      q_valid_o,
  output item_t                     q_item_o,
  input  wire logic                 q_pop_i
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              full;
  logic              push;
  item_t             item;
  logic [N_W-1:0]    n;

  // Classify the word so the back end only dispatches.
  always_comb begin
    n               = bars_in_use(cfg_i);
    item.bar        = bar_index_i;
    item.level      = level_i;
    item.tick_ms    = tick_ms_i;
    if (action_i) begin
      item.op = (tick_ms_i == '0) ? OP_STATUS : OP_TICK;
    end else begin
      item.op = (CMP_W'(bar_index_i) >= CMP_W'(n)) ? OP_STATUS : OP_LEVEL;
    end
  end

  assign full       = (count_q == QCNT_W'(QDEPTH));
  assign push       = in_valid_i && !full;
  assign in_stall_o = full;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count above its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != '0)
    else $error("back end popped an empty queue");

endmodule

`default_nettype wire

>>> hdl/blpd_div.sv
`default_nettype none

module blpd_div
  import blpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MS_W-1:0]     dividend_i,
  input  wire logic [STEPMS_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [MS_W-1:0]          quotient_o,
  output logic [STEPMS_W-1:0]      remainder_o
);

  localparam int unsigned DCNT_W = $clog2(MS_W + 1);

  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [MS_W-1:0]     quo_q, quo_d;
  logic [STEPMS_W-1:0] rem_q, rem_d;
  logic [STEPMS_W-1:0] div_q, div_d;
  logic [STEPMS_W:0]   trial;
  logic                ge;

  // Restoring division, one quotient bit a cycle, MSB first.
  always_comb begin
    trial  = {rem_q, quo_q[MS_W-1]};
    ge     = (trial >= {1'b0, div_q});
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = DCNT_W'(MS_W);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DCNT_W'(1);
      quo_d  = {quo_q[MS_W-2:0], ge};
      rem_d  = ge ? STEPMS_W'(trial - {1'b0, div_q}) : STEPMS_W'(trial);
      done_d = (cnt_q == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < div_q)
    else $error("division remainder not below divisor");

endmodule

`default_nettype wire

>>> hdl/blpd_back.sv
`default_nettype none

module blpd_back
  import blpd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  q_valid_i,
  input  wire item_t q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  output result_t    out_o,
  input  wire logic  out_stall_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STAT,
    S_LVL,
    S_DIV,
    S_RD,
    S_LOAD,
    S_STEP,
    S_WR,
    S_ORD,
    S_OEMIT
  } state_e;

  state_e              state_q, state_d;
  logic                busy_q, busy_d;
  logic [MS_W-1:0]     acc_q, acc_d;
  logic [BAR_W-1:0]    idx_q, idx_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic [STEP_W-1:0]   kleft_q, kleft_d;
  logic                changed_q, changed_d;
  lvl_t                cur_q, cur_d;
  item_t               item_q, item_d;
  logic [BARS-1:0]     valid_q, valid_d;
  logic [BARS-1:0]     unsettled_q, unsettled_d;
  logic                rvalid_q, rvalid_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                ram_we, ram_re;
  logic [BAR_W-1:0]    ram_waddr, ram_raddr;
  lvl_t                ram_wdata, ram_rdata, rd_lvl;

  logic                div_start, div_done;
  logic [MS_W-1:0]     div_dividend, div_quo;
  logic [STEPMS_W-1:0] div_divisor, div_rem;

  logic [N_W-1:0]      n;
  logic [BARS-1:0]     in_use;
  logic                last_bar;
  logic                out_free;
  logic [BAR_W-1:0]    bar_addr;

  lvl_t                lvl_new;
  logic                lvl_rose;
  logic [BARS-1:0]     lvl_unsettled;
  logic                lvl_need;

  lvl_t                step_lvl;
  logic                step_ch;
  logic [LEVEL_W-1:0]  fall, gap, pfall;

  blpd_ram #(
    .WIDTH($bits(lvl_t)),
    .DEPTH(BARS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  blpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // A bar never written reads as all zero.
  assign rd_lvl   = rvalid_q ? ram_rdata : '0;
  assign out_free = !out_valid_q || !out_stall_i;
  assign bar_addr = BAR_W'(item_q.bar);
  assign last_bar = ((N_W'(idx_q) + N_W'(1)) == n);

  assign div_dividend = acc_q + q_item_i.tick_ms;
  assign div_divisor  = (cfg_i.step_ms == '0) ? STEPMS_W'(1) : cfg_i.step_ms;

  always_comb begin
    n = bars_in_use(cfg_i);
    for (int i = 0; i < int'(BARS); i++) begin
      in_use[i] = (N_W'(i) < n);
    end
  end

  // New level for one bar: shown jumps up, peak follows shown.
  always_comb begin
    lvl_new.target = item_q.level;
    lvl_new.shown  = (item_q.level > rd_lvl.shown) ? item_q.level : rd_lvl.shown;
    lvl_new.peak   = (lvl_new.shown > rd_lvl.peak) ? lvl_new.shown : rd_lvl.peak;
    lvl_rose       = (item_q.level > rd_lvl.shown) || (lvl_new.shown > rd_lvl.peak);
    lvl_unsettled  = unsettled_q;
    lvl_unsettled[bar_addr] = (lvl_new.shown > lvl_new.target) ||
                              (lvl_new.peak > lvl_new.shown);
    lvl_need       = |(lvl_unsettled & in_use);
  end

  // One decay step of the working bar.
  always_comb begin
    step_lvl        = cur_q;
    fall            = (cur_q.shown - cur_q.target) >> cfg_i.fall_shift;
    if (fall == '0) begin
      fall = LEVEL_W'(1);
    end
    if (cur_q.shown > cur_q.target) begin
      step_lvl.shown = cur_q.shown - fall;
    end
    gap   = cur_q.peak - step_lvl.shown;
    pfall = (cfg_i.peak_fall > gap) ? gap : cfg_i.peak_fall;
    if (cur_q.peak > step_lvl.shown) begin
      step_lvl.peak = cur_q.peak - pfall;
    end
    step_ch = (cur_q.shown > cur_q.target) ||
              ((cur_q.peak > step_lvl.shown) && (pfall != '0));
  end

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    kleft_d     = kleft_q;
    changed_d   = changed_q;
    cur_d       = cur_q;
    item_d      = item_q;
    valid_d     = valid_q;
    unsettled_d = unsettled_q;
    rvalid_d    = rvalid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = cur_q;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          case (q_item_i.op)
            OP_LEVEL: begin
              ram_re    = 1'b1;
              ram_raddr = BAR_W'(q_item_i.bar);
              state_d   = S_LVL;
            end
            OP_TICK: begin
              if (busy_q) begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end else begin
                state_d = S_STAT;
              end
            end
            default: state_d = S_STAT;
          endcase
        end
      end

      S_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.decaying = busy_q;
          out_d.last     = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_LVL: begin
        if (out_free) begin
          ram_we                = 1'b1;
          ram_waddr             = bar_addr;
          ram_wdata             = lvl_new;
          valid_d[bar_addr]     = 1'b1;
          unsettled_d           = lvl_unsettled;
          busy_d                = busy_q || lvl_need;
          if (lvl_need && !busy_q) begin
            acc_d = '0;
          end
          out_valid_d       = 1'b1;
          out_d.has_bar     = 1'b1;
          out_d.out_bar     = item_q.bar;
          out_d.shown_level = lvl_new.shown;
          out_d.peak_level  = lvl_new.peak;
          out_d.redraw      = lvl_rose;
          out_d.decaying    = busy_q || lvl_need;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          acc_d = MS_W'(div_rem);
          if (div_quo == '0) begin
            state_d = S_STAT;
          end else begin
            steps_d   = (div_quo > MS_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                     : STEP_W'(div_quo);
            idx_d     = '0;
            changed_d = 1'b0;
            state_d   = S_RD;
          end
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_LOAD;
      end

      S_LOAD: begin
        cur_d   = rd_lvl;
        kleft_d = steps_q;
        state_d = S_STEP;
      end

      S_STEP: begin
        cur_d   = step_lvl;
        kleft_d = kleft_q - STEP_W'(1);
        if (step_ch) begin
          changed_d = 1'b1;
        end
        if (kleft_q == STEP_W'(1)) begin
          state_d = S_WR;
        end
      end

      S_WR: begin
        ram_we             = 1'b1;
        valid_d[idx_q]     = 1'b1;
        unsettled_d[idx_q] = (cur_q.shown > cur_q.target) || (cur_q.peak > cur_q.shown);
        if (last_bar) begin
          if (changed_q) begin
            idx_d   = '0;
            state_d = S_ORD;
          end else begin
            // Nothing moved: decay is over.
            busy_d  = 1'b0;
            acc_d   = '0;
            state_d = S_STAT;
          end
        end else begin
          idx_d   = idx_q + BAR_W'(1);
          state_d = S_RD;
        end
      end

      S_ORD: begin
        ram_re  = 1'b1;
        state_d = S_OEMIT;
      end

      S_OEMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.has_bar     = 1'b1;
          out_d.out_bar     = BAR_IDX_W'(idx_q);
          out_d.shown_level = rd_lvl.shown;
          out_d.peak_level  = rd_lvl.peak;
          out_d.redraw      = 1'b1;
          out_d.decaying    = busy_q;
          out_d.last        = last_bar;
          if (last_bar) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + BAR_W'(1);
            state_d = S_ORD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (ram_re) begin
      rvalid_d = valid_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      steps_q     <= '0;
      kleft_q     <= '0;
      changed_q   <= 1'b0;
      cur_q       <= '0;
      item_q      <= '0;
      valid_q     <= '0;
      unsettled_q <= '0;
      rvalid_q    <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
      kleft_q     <= kleft_d;
      changed_q   <= changed_d;
      cur_q       <= cur_d;
      item_q      <= item_d;
      valid_q     <= valid_d;
      unsettled_q <= unsettled_d;
      rvalid_q    <= rvalid_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_stop_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> acc_q == '0)
    else $error("decay stopped with a nonzero accumulator");

  a_sweep_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_ORD) |-> N_W'(idx_q) < n)
    else $error("bar sweep ran past the bars in use");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEP |-> kleft_q != '0 && kleft_q <= STEP_W'(MAX_STEPS))
    else $error("decay step counter out of range");

endmodule

`default_nettype wire

>>> hdl/bar_level_peak_decay_core.sv
`default_nettype none

// Channel  Dir  Handshake                   Word
// in       in   in_valid_i / in_stall_o     action_i bar_index_i level_i tick_ms_i
// out      out  out_valid_o / out_stall_i   has_bar_o out_bar_o shown_level_o peak_level_o
//                                           redraw_o decaying_o last_o
// cfg      in   cfg_we_i                    cfg_index_i cfg_wdata_i
//
// Back end: a level word is popped with a store read and its result then sent; a status
// word is popped and then answered. A tick while decaying is popped and divided; each bar in
// use is then read, stepped k times (k from 1 to 4) and written back, and the results read out.
// Reset needs no clearing pass: per-bar valid bits make unwritten bars read as zero.
// A two-word queue takes input while the back end works, and the output register holds a
// stalled result while the back end moves on to its next step.

module bar_level_peak_decay_core
  import blpd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  action_i,
  input  wire logic [BAR_IDX_W-1:0]  bar_index_i,
  input  wire logic [LEVEL_W-1:0]    level_i,
  input  wire logic [MS_W-1:0]       tick_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       has_bar_o,
  output logic [BAR_IDX_W-1:0]       out_bar_o,
  output logic [LEVEL_W-1:0]         shown_level_o,
  output logic [LEVEL_W-1:0]         peak_level_o,
  output logic                       redraw_o,
  output logic                       decaying_o,
  output logic                       last_o
);

  cfg_t    cfg_q, cfg_d;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BAR_COUNT:  cfg_d.bar_count  = cfg_wdata_i[CNT_W-1:0];
        CFG_FALL_SHIFT: cfg_d.fall_shift = cfg_wdata_i[SHIFT_W-1:0];
        CFG_PEAK_FALL:  cfg_d.peak_fall  = cfg_wdata_i[PFALL_W-1:0];
        CFG_STEP_MS:    cfg_d.step_ms    = cfg_wdata_i[STEPMS_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bar_count  <= CNT_W'(32);
      cfg_q.fall_shift <= SHIFT_W'(2);
      cfg_q.peak_fall  <= PFALL_W'(2);
      cfg_q.step_ms    <= STEPMS_W'(20);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  blpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .bar_index_i (bar_index_i),
    .level_i     (level_i),
    .tick_ms_i   (tick_ms_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  blpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_o      (res),
    .out_stall_i(out_stall_i)
  );

  assign has_bar_o     = res.has_bar;
  assign out_bar_o     = res.out_bar;
  assign shown_level_o = res.shown_level;
  assign peak_level_o  = res.peak_level;
  assign redraw_o      = res.redraw;
  assign decaying_o    = res.decaying;
  assign last_o        = res.last;

endmodule

`default_nettype wire

>>> tb/tb_bar_level_peak_decay_core.sv
module tb_bar_level_peak_decay_core;
  import blpd_pkg::*;

  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                 action;
    logic [BAR_IDX_W-1:0] bar;
    logic [LEVEL_W-1:0]   level;
    logic [MS_W-1:0]      elapsed;
  } meter_word_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic        tx_valid = 1'b0;
  meter_word_t tx_word = '0;
  logic        out_stall = 1'b0;
  logic        rx_hold = 1'b0;
  logic        hold_arm = 1'b0;

  logic                 in_stall;
  logic                 out_valid;
  logic                 has_bar;
  logic [BAR_IDX_W-1:0] out_bar;
  logic [LEVEL_W-1:0]   shown_level;
  logic [LEVEL_W-1:0]   peak_level;
  logic                 redraw;
  logic                 decaying;
  logic                 last;

  int tx_pct = 0;
  int rx_pct = 0;
  int mismatches = 0;

  meter_word_t pending_words[$];
  result_t     expected_levels[$];

  // Own copy of the meter state and registers.
  logic [LEVEL_W-1:0]  meter_target[BARS];
  logic [LEVEL_W-1:0]  meter_shown[BARS];
  logic [LEVEL_W-1:0]  meter_peak[BARS];
  logic [MS_W-1:0]     meter_acc;
  logic                meter_busy;
  logic [CNT_W-1:0]    cur_bar_count;
  logic [SHIFT_W-1:0]  cur_fall_shift;
  logic [PFALL_W-1:0]  cur_peak_fall;
  logic [STEPMS_W-1:0] cur_step_ms;

  bar_level_peak_decay_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (tx_valid),
    .in_stall_o    (in_stall),
    .action_i      (tx_word.action),
    .bar_index_i   (tx_word.bar),
    .level_i       (tx_word.level),
    .tick_ms_i     (tx_word.elapsed),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .has_bar_o     (has_bar),
    .out_bar_o     (out_bar),
    .shown_level_o (shown_level),
    .peak_level_o  (peak_level),
    .redraw_o      (redraw),
    .decaying_o    (decaying),
    .last_o        (last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int bars_used();
    int n;
    n = int'(cur_bar_count);
    if (n == 0) begin
      n = 1;
    end
    if (n > int'(BARS)) begin
      n = BARS;
    end
    return n;
  endfunction

  function automatic int step_len();
    return (cur_step_ms == '0) ? 1 : int'(cur_step_ms);
  endfunction

  task automatic push_status();
    result_t r;
    r = '0;
    r.decaying = meter_busy;
    r.last = 1'b1;
    expected_levels.push_back(r);
  endtask

  task automatic decay_all(input int n, output bit changed);
    int s, t, p, d, f;
    changed = 1'b0;
    for (int i = 0; i < n; i++) begin
      s = meter_shown[i];
      t = meter_target[i];
      p = meter_peak[i];
      if (s > t) begin
        d = (s - t) >> cur_fall_shift;
        if (d == 0) begin
          d = 1;
        end
        s = s - d;
        changed = 1'b1;
      end
      if (p > s) begin
        f = cur_peak_fall;
        if (f > p - s) begin
          f = p - s;
        end
        if (f != 0) begin
          p = p - f;
          changed = 1'b1;
        end
      end
      meter_shown[i] = s[LEVEL_W-1:0];
      meter_peak[i] = p[LEVEL_W-1:0];
    end
  endtask

  // Works out the results of one accepted word and updates the meter state.
  task automatic predict_levels(input meter_word_t w);
    int n, sm, acc, steps;
    bit rose, need, changed, ch;
    result_t r;
    n = bars_used();
    rose = 1'b0;
    need = 1'b0;
    changed = 1'b0;
    if (w.action == 1'b0) begin
      if (int'(w.bar) >= n) begin
        push_status();
        return;
      end
      meter_target[w.bar] = w.level;
      if (w.level > meter_shown[w.bar]) begin
        meter_shown[w.bar] = w.level;
        rose = 1'b1;
      end
      if (meter_shown[w.bar] > meter_peak[w.bar]) begin
        meter_peak[w.bar] = meter_shown[w.bar];
        rose = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        if (meter_shown[i] > meter_target[i] || meter_peak[i] > meter_shown[i]) begin
          need = 1'b1;
        end
      end
      if (need && !meter_busy) begin
        meter_busy = 1'b1;
        meter_acc = '0;
      end
      r = '0;
      r.has_bar = 1'b1;
      r.out_bar = w.bar;
      r.shown_level = meter_shown[w.bar];
      r.peak_level = meter_peak[w.bar];
      r.redraw = rose;
      r.decaying = meter_busy;
      r.last = 1'b1;
      expected_levels.push_back(r);
    end else begin
      sm = step_len();
      if (!meter_busy || w.elapsed == '0) begin
        push_status();
        return;
      end
      acc = (int'(meter_acc) + int'(w.elapsed)) & 32'hFFFF;
      steps = acc / sm;
      meter_acc = MS_W'(acc % sm);
      if (steps == 0) begin
        push_status();
        return;
      end
      if (steps > int'(MAX_STEPS)) begin
        steps = MAX_STEPS;
      end
      repeat (steps) begin
        decay_all(n, ch);
        changed = changed | ch;
      end
      if (!changed) begin
        meter_busy = 1'b0;
        meter_acc = '0;
        push_status();
        return;
      end
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.has_bar = 1'b1;
        r.out_bar = BAR_IDX_W'(i);
        r.shown_level = meter_shown[i];
        r.peak_level = meter_peak[i];
        r.redraw = 1'b1;
        r.decaying = 1'b1;
        r.last = (i == n - 1);
        expected_levels.push_back(r);
      end
    end
  endtask

  // A word stays on the bus until it is taken; a new one may follow in the next cycle.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (tx_valid && !in_stall) begin
        predict_levels(tx_word);
      end
      if (!tx_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_pct) begin
          tx_word <= pending_words.pop_front();
          tx_valid <= 1'b1;
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{has_bar, out_bar, shown_level, peak_level, redraw, decaying, last};
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: got %p", got);
          end
        end else begin
          want = expected_levels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %p, got %p", want, got);
            end
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < rx_pct);
    end
  end

  // One long hold-off of the receiver while the sender keeps offering words.
  initial begin
    wait (hold_arm);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(12 * 500000);
    $display("bar_level_peak_decay_core test failed");
    $finish;
  end

  task automatic write_reg(input cfg_reg_e idx, input int val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_BAR_COUNT:  cur_bar_count = CNT_W'(val);
      CFG_FALL_SHIFT: cur_fall_shift = SHIFT_W'(val);
      CFG_PEAK_FALL:  cur_peak_fall = PFALL_W'(val);
      CFG_STEP_MS:    cur_step_ms = STEPMS_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input int bc, input int fs, input int pf, input int sm);
    write_reg(CFG_BAR_COUNT, bc);
    write_reg(CFG_FALL_SHIFT, fs);
    write_reg(CFG_PEAK_FALL, pf);
    write_reg(CFG_STEP_MS, sm);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_word(input bit act, input int bar, input int lvl, input int ms);
    meter_word_t w;
    w.action = act;
    w.bar = BAR_IDX_W'(bar);
    w.level = LEVEL_W'(lvl);
    w.elapsed = MS_W'(ms);
    pending_words.push_back(w);
  endtask

  // Mostly level words for bars in use and ticks near whole steps; some noise.
  task automatic queue_random(input int count);
    int r, n, sm;
    n = bars_used();
    sm = step_len();
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 10) begin
        queue_word($urandom_range(1), $urandom_range(31), $urandom_range(255),
                   $urandom_range(65535));
      end else if (r < 68) begin
        queue_word(1'b0, $urandom_range(n - 1), $urandom_range(255), $urandom_range(65535));
      end else if (r < 73) begin
        queue_word(1'b1, $urandom_range(31), $urandom_range(255), $urandom_range(65535));
      end else begin
        queue_word(1'b1, $urandom_range(31), $urandom_range(255),
                   sm * $urandom_range(4) + $urandom_range(sm - 1));
      end
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || tx_valid || expected_levels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input int bc, input int fs, input int pf, input int sm,
                           input int tx, input int rx, input int count);
    set_config(bc, fs, pf, sm);
    tx_pct = tx;
    rx_pct = rx;
    queue_random(count);
    drain();
  endtask

  initial begin
    for (int i = 0; i < BARS; i++) begin
      meter_target[i] = '0;
      meter_shown[i] = '0;
      meter_peak[i] = '0;
    end
    meter_acc = '0;
    meter_busy = 1'b0;
    cur_bar_count = CNT_W'(32);
    cur_fall_shift = SHIFT_W'(2);
    cur_peak_fall = PFALL_W'(2);
    cur_step_ms = STEPMS_W'(20);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Directed words on the reset settings.
    queue_word(1'b1, 0, 0, 100);
    queue_word(1'b0, 0, 255, 0);
    queue_word(1'b0, 31, 200, 0);
    queue_word(1'b0, 0, 0, 0);
    queue_word(1'b1, 0, 0, 0);
    queue_word(1'b1, 0, 0, 10);
    queue_word(1'b1, 0, 0, 10);
    queue_word(1'b1, 0, 0, 65535);
    queue_word(1'b1, 0, 0, 65535);
    queue_word(1'b0, 31, 255, 0);
    queue_word(1'b0, 5, 128, 0);
    queue_word(1'b0, 5, 0, 0);
    queue_word(1'b0, 31, 0, 0);
    queue_word(1'b0, 21, 170, 0);
    queue_word(1'b0, 10, 85, 0);
    repeat (6) queue_word(1'b1, 0, 0, 80);
    queue_word(1'b0, 17, 1, 0);
    queue_word(1'b1, 0, 0, 65535);
    drain();

    run_phase(63, 0, 255, 1, 45, 0, 45);
    run_phase(1, 7, 1, 1000, 0, 45, 35);
    run_phase(0, 3, 0, 0, 17, 17, 35);

    // The receiver holds off while words keep coming, so the input backs up.
    set_config(8, 1, 16, 7);
    tx_pct = 0;
    rx_pct = 0;
    queue_random(40);
    hold_arm = 1'b1;
    drain();

    run_phase(32, 5, 4, 33, 17, 17, 45);

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("bar_level_peak_decay_core test passed");
    end else begin
      $display("bar_level_peak_decay_core test failed");
    end
    $finish;
  end

endmodule
